FILE: design/mplsf_pkg.sv
// ----------------------------------------------------------------------------
// MPL seed-set duplicate filter package
// Shared types and constants for the seed-set duplicate filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mplsf_pkg;

  // Number of seed table entries and the width of an entry index.
  localparam int unsigned SEED_ENTRIES = 32;
  localparam int unsigned IDX_W        = (SEED_ENTRIES > 1) ? $clog2(SEED_ENTRIES) : 1;

  // Fixed field widths.
  localparam int unsigned SEED_W       = 16;
  localparam int unsigned SEQ_W        = 8;
  localparam int unsigned LIFE_W       = 8;
  localparam int unsigned ENTRY_IDX_W  = 5;

  // Reset value of the entry lifetime register.
  localparam logic [LIFE_W-1:0] LIFETIME_RESET = 8'd4;

  // Operation codes.
  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Seed id length codes.
  localparam logic [1:0] LEN_ELIDED  = 2'd0;
  localparam logic [1:0] LEN_TWO_OCT = 2'd1;

  // Verdict codes.
  typedef enum logic [2:0] {
    V_NEW       = 3'd0,
    V_LOCAL     = 3'd1,
    V_MALFORMED = 3'd2,
    V_STALE     = 3'd3,
    V_FULL      = 3'd4,
    V_TICK      = 3'd5
  } verdict_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SCAN,
    ST_RESOLVE
  } state_e;

  // Input item.
  typedef struct packed {
    logic              opcode;
    logic              option_complete;
    logic [1:0]        length_code;
    logic [SEED_W-1:0] option_seed_id;
    logic [SEED_W-1:0] source_low_bits;
    logic [SEQ_W-1:0]  sequence_req;
    logic              is_outbound;
  } cmd_t;

  // Result item.
  typedef struct packed {
    verdict_e               verdict;
    logic [SEED_W-1:0]      effective_seed;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   restart_lifetime_timer;
  } result_t;

endpackage

`default_nettype wire

FILE: design/mpl_seed_set_duplicate_filter_core.sv
// A malformed option gives its result in the cycle after it is taken. A tick walks all
// SEED_ENTRIES entries, one per cycle, and its result is registered at the end of the walk.
// A check walks entries up to the first live match (at most SEED_ENTRIES), then a resolve
// state does the sequence compare and table write; its result is registered there.
// The core takes one item at a time: busy stays high while a tick or check walks, so a new
// item is taken only once the core is idle again. Reset frees every entry and loads the
// lifetime register with 4; results cannot be stalled.
// ----------------------------------------------------------------------------
// MPL seed-set duplicate filter core
// Seed table with a sequential entry walk that filters duplicate MPL messages
// and ages entry lifetimes on tick items.
// ----------------------------------------------------------------------------
`default_nettype none

module mpl_seed_set_duplicate_filter_core
  import mplsf_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire cmd_t              cmd_i,
  output logic                   done_o,
  output result_t                result_o,
  input  wire logic              cfg_we_i,
  input  wire logic [LIFE_W-1:0] cfg_wdata_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEED_ENTRIES - 1);

  // Seed table storage. Lifetimes are cleared by reset; ids and sequences
  // are only read for live entries, so they need no reset.
  logic [LIFE_W-1:0] lifetime_q [SEED_ENTRIES];
  logic [SEED_W-1:0] seed_mem   [SEED_ENTRIES];
  logic [SEQ_W-1:0]  seq_mem    [SEED_ENTRIES];

  // Sequencer and item registers.
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  tgt_q, tgt_d;
  logic [IDX_W-1:0]  free_idx_q, free_idx_d;
  logic              have_free_q, have_free_d;
  logic              matched_q, matched_d;
  logic              any_live_q, any_live_d;
  logic [SEED_W-1:0] seed_q, seed_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic              outbound_q, outbound_d;
  logic [LIFE_W-1:0] entry_lifetime_q;
  logic              done_q, done_d;
  result_t           result_q, result_d;

  // Table write controls.
  logic              lt_we;
  logic [IDX_W-1:0]  lt_addr;
  logic [LIFE_W-1:0] lt_wdata;
  logic              ent_we;

  // Values read at the walk index and at the resolve target.
  logic [LIFE_W-1:0] cur_life;
  logic              cur_live;
  logic [SEQ_W-1:0]  diff;
  logic              stale;
  logic              accept;

  assign accept   = start && !busy;
  assign busy     = (state_q != ST_IDLE);
  assign cur_life = lifetime_q[idx_q];
  assign cur_live = (cur_life != '0);
  assign diff     = seq_q - seq_mem[tgt_q];
  assign stale    = (diff == '0) || diff[SEQ_W-1];

  assign done_o   = done_q;
  assign result_o = result_q;

  // Next state, walk bookkeeping and result formation.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    free_idx_d  = free_idx_q;
    have_free_d = have_free_q;
    matched_d   = matched_q;
    any_live_d  = any_live_q;
    seed_d      = seed_q;
    seq_d       = seq_q;
    outbound_d  = outbound_q;
    done_d      = 1'b0;
    result_d    = result_q;
    lt_we       = 1'b0;
    lt_addr     = idx_q;
    lt_wdata    = cur_life - LIFE_W'(1);
    ent_we      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d       = '0;
          have_free_d = 1'b0;
          matched_d   = 1'b0;
          any_live_d  = 1'b0;
          seq_d       = cmd_i.sequence_req;
          outbound_d  = cmd_i.is_outbound;
          seed_d      = (cmd_i.length_code == LEN_ELIDED) ? cmd_i.source_low_bits
                                                          : cmd_i.option_seed_id;
          if (cmd_i.opcode == OP_TICK) begin
            state_d = ST_TICK;
          end else if (!cmd_i.option_complete ||
                       (cmd_i.length_code != LEN_ELIDED &&
                        cmd_i.length_code != LEN_TWO_OCT)) begin
            done_d   = 1'b1;
            result_d = '{verdict: V_MALFORMED, effective_seed: '0,
                         entry_index: '0, restart_lifetime_timer: 1'b0};
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      // Age one live entry per cycle.
      ST_TICK: begin
        if (cur_live) begin
          lt_we      = 1'b1;
          any_live_d = 1'b1;
        end
        idx_d = idx_q + IDX_W'(1);
        if (idx_q == LAST_IDX) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          result_d = '{verdict: V_TICK, effective_seed: '0, entry_index: '0,
                       restart_lifetime_timer: any_live_q || cur_live};
        end
      end

      // Look for the first live match, noting the first free entry.
      ST_SCAN: begin
        if (!cur_live && !have_free_q) begin
          have_free_d = 1'b1;
          free_idx_d  = idx_q;
        end
        idx_d = idx_q + IDX_W'(1);
        if (cur_live && seed_mem[idx_q] == seed_q) begin
          matched_d = 1'b1;
          tgt_d     = idx_q;
          state_d   = ST_RESOLVE;
        end else if (idx_q == LAST_IDX) begin
          tgt_d   = (!cur_live && !have_free_q) ? idx_q : free_idx_q;
          state_d = ST_RESOLVE;
        end
      end

      // Compare sequences or claim the free entry, then report.
      ST_RESOLVE: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
        if (matched_q && stale) begin
          result_d = '{verdict: outbound_q ? V_LOCAL : V_STALE, effective_seed: seed_q,
                       entry_index: ENTRY_IDX_W'(tgt_q), restart_lifetime_timer: 1'b0};
        end else if (matched_q || have_free_q) begin
          lt_we    = 1'b1;
          lt_addr  = tgt_q;
          lt_wdata = entry_lifetime_q;
          ent_we   = 1'b1;
          result_d = '{verdict: V_NEW, effective_seed: seed_q,
                       entry_index: ENTRY_IDX_W'(tgt_q), restart_lifetime_timer: 1'b1};
        end else begin
          result_d = '{verdict: outbound_q ? V_LOCAL : V_FULL, effective_seed: seed_q,
                       entry_index: '0, restart_lifetime_timer: 1'b0};
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      done_q           <= 1'b0;
      entry_lifetime_q <= LIFETIME_RESET;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        entry_lifetime_q <= cfg_wdata_i;
      end
    end
  end

  // Item and walk registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    tgt_q       <= tgt_d;
    free_idx_q  <= free_idx_d;
    have_free_q <= have_free_d;
    matched_q   <= matched_d;
    any_live_q  <= any_live_d;
    seed_q      <= seed_d;
    seq_q       <= seq_d;
    outbound_q  <= outbound_d;
    result_q    <= result_d;
  end

  // Lifetime array; reset frees every entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SEED_ENTRIES; i++) begin
        lifetime_q[i] <= '0;
      end
    end else if (lt_we) begin
      lifetime_q[lt_addr] <= lt_wdata;
    end
  end

  // Seed id and sequence arrays.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      seed_mem[tgt_q] <= seed_q;
      seq_mem[tgt_q]  <= seq_q;
    end
  end

endmodule

`default_nettype wire

FILE: test/tb_mpl_seed_set_duplicate_filter_core.sv
// ----------------------------------------------------------------------------
// Seed-set duplicate filter testbench
// Drives check and tick items into the filter core and compares every result
// against a local model of the seed table. The model is updated as each item
// is taken. Directed tests cover malformed options, serial sequence limits,
// expiry, a full table and the lifetime register extremes. Random traffic
// from small seed pools follows, under several lifetime settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_mpl_seed_set_duplicate_filter_core;
  import mplsf_pkg::*;

  localparam int TIMEOUT_CYCLES = 600000;
  localparam int POOL_SIZE      = 40;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  cmd_t              cmd;
  logic              done;
  result_t           result;
  logic              cfg_we;
  logic [LIFE_W-1:0] cfg_wdata;

  // Local copy of the seed table and the lifetime register.
  logic [SEED_W-1:0] seed_id_tab  [SEED_ENTRIES];
  logic [SEQ_W-1:0]  last_seq_tab [SEED_ENTRIES];
  logic [LIFE_W-1:0] life_tab     [SEED_ENTRIES];
  logic [LIFE_W-1:0] lifetime_reg;

  result_t pending_results[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      max_gap     = 12;

  // Random traffic draws seeds from a small pool so entries are revisited.
  logic [SEED_W-1:0] pool_seed [POOL_SIZE];
  logic [SEQ_W-1:0]  pool_seq  [POOL_SIZE];

  mpl_seed_set_duplicate_filter_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd),
    .done_o      (done),
    .result_o    (result),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Guard against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Computes the result of one item and applies its effect to the table.
  function automatic result_t filter_predict(input cmd_t item);
    result_t           res;
    logic              any_live;
    logic              found_free;
    logic              found_match;
    logic [SEED_W-1:0] seed;
    logic [SEQ_W-1:0]  diff;
    int                free_at;
    int                match_at;
    int                target;
    res = '0;
    if (item.opcode == OP_TICK) begin
      any_live = 1'b0;
      for (int i = 0; i < SEED_ENTRIES; i++) begin
        if (life_tab[i] != '0) begin
          life_tab[i] = life_tab[i] - 1'b1;
          any_live    = 1'b1;
        end
      end
      res.verdict                = V_TICK;
      res.restart_lifetime_timer = any_live;
      return res;
    end
    if (!item.option_complete || item.length_code > LEN_TWO_OCT) begin
      res.verdict = V_MALFORMED;
      return res;
    end
    seed = (item.length_code == LEN_ELIDED) ? item.source_low_bits : item.option_seed_id;
    res.effective_seed = seed;
    found_free  = 1'b0;
    found_match = 1'b0;
    free_at     = 0;
    match_at    = 0;
    // The walk stops at the first live match; free entries before it are noted.
    for (int i = 0; i < SEED_ENTRIES; i++) begin
      if (life_tab[i] == '0) begin
        if (!found_free) begin
          found_free = 1'b1;
          free_at    = i;
        end
      end else if (seed_id_tab[i] == seed) begin
        found_match = 1'b1;
        match_at    = i;
        break;
      end
    end
    if (found_match) begin
      diff = item.sequence_req - last_seq_tab[match_at];
      if (diff == '0 || diff[SEQ_W-1]) begin
        res.verdict     = item.is_outbound ? V_LOCAL : V_STALE;
        res.entry_index = match_at[ENTRY_IDX_W-1:0];
        return res;
      end
      target = match_at;
    end else if (found_free) begin
      target = free_at;
    end else begin
      res.verdict = item.is_outbound ? V_LOCAL : V_FULL;
      return res;
    end
    seed_id_tab[target]        = seed;
    last_seq_tab[target]       = item.sequence_req;
    life_tab[target]           = lifetime_reg;
    res.verdict                = V_NEW;
    res.entry_index            = target[ENTRY_IDX_W-1:0];
    res.restart_lifetime_timer = 1'b1;
    return res;
  endfunction

  // Counts a mismatch and reports the first ten of them.
  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected verdict %0d seed %h entry %0d restart %0b,",
               $realtime, what, want.verdict, want.effective_seed, want.entry_index,
               want.restart_lifetime_timer);
      $display("    got verdict %0d seed %h entry %0d restart %0b",
               got.verdict, got.effective_seed, got.entry_index,
               got.restart_lifetime_timer);
    end
  endtask

  // Each result is compared with the oldest pending expectation.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with nothing pending", '0, result);
      end else begin
        want = pending_results.pop_front();
        if (result.verdict !== want.verdict ||
            result.effective_seed !== want.effective_seed ||
            result.entry_index !== want.entry_index ||
            result.restart_lifetime_timer !== want.restart_lifetime_timer) begin
          note_mismatch("result mismatch", want, result);
        end
      end
    end
  end

  // Sends one item after a random gap and records its expected result.
  task automatic issue_item(input cmd_t item, output result_t predicted);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start <= 1'b1;
    cmd   <= item;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    predicted = filter_predict(item);
    pending_results.push_back(predicted);
  endtask

  // Lets every pending result arrive and the block fall idle.
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SEED_ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic write_lifetime(input logic [LIFE_W-1:0] value);
    settle();
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    lifetime_reg = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic cmd_t check_item(input logic complete, input logic [1:0] code,
                                      input logic [SEED_W-1:0] opt_seed,
                                      input logic [SEED_W-1:0] src_seed,
                                      input logic [SEQ_W-1:0] seq, input logic outbound);
    cmd_t item;
    item.opcode          = OP_CHECK;
    item.option_complete = complete;
    item.length_code     = code;
    item.option_seed_id  = opt_seed;
    item.source_low_bits = src_seed;
    item.sequence_req    = seq;
    item.is_outbound     = outbound;
    return item;
  endfunction

  // Tick items carry random content in the fields the block ignores.
  function automatic cmd_t tick_item();
    cmd_t        item;
    logic [63:0] raw;
    raw         = {$urandom, $urandom};
    item        = raw[$bits(cmd_t)-1:0];
    item.opcode = OP_TICK;
    return item;
  endfunction

  task automatic send_check(input logic complete, input logic [1:0] code,
                            input logic [SEED_W-1:0] opt_seed,
                            input logic [SEED_W-1:0] src_seed,
                            input logic [SEQ_W-1:0] seq, input logic outbound);
    result_t unused;
    issue_item(check_item(complete, code, opt_seed, src_seed, seq, outbound), unused);
  endtask

  task automatic send_ticks(input int count);
    result_t unused;
    repeat (count) issue_item(tick_item(), unused);
  endtask

  task automatic apply_reset();
    start     = 1'b0;
    cmd       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_ni    = 1'b0;
    for (int i = 0; i < SEED_ENTRIES; i++) begin
      seed_id_tab[i]  = '0;
      last_seq_tab[i] = '0;
      life_tab[i]     = '0;
    end
    lifetime_reg = LIFETIME_RESET;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  endtask

  // Malformed options, serial sequence limits and expiry under the reset lifetime.
  task automatic test_sequence_rules();
    max_gap = 12;
    send_ticks(1);
    send_check(1'b0, LEN_ELIDED, 16'h1234, 16'hABCD, 8'h01, 1'b0);
    send_check(1'b1, 2'd2, 16'h1234, 16'hABCD, 8'h01, 1'b0);
    send_check(1'b1, 2'd3, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);
    send_check(1'b1, LEN_ELIDED, 16'h0000, 16'hFFFF, 8'h00, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'h0000, 16'h5A5A, 8'hFF, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h0000, 8'h00, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h0000, 8'h80, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h0000, 8'h80, 1'b1);
    max_gap = 0;
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h0000, 8'h7F, 1'b0);
    send_check(1'b1, LEN_ELIDED, 16'h1111, 16'hFFFF, 8'h80, 1'b0);
    send_check(1'b1, LEN_ELIDED, 16'hFFFF, 16'h0000, 8'h00, 1'b1);
    // Ticks age both entries out; the last one finds nothing live.
    send_ticks(5);
    max_gap = 12;
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h2222, 8'h80, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hFFFF, 16'h2222, 8'h80, 1'b1);
    send_ticks(4);
  endtask

  // Fills every entry, then checks the full verdict and its local form.
  task automatic test_table_full();
    logic [SEED_W-1:0] fill_seed [SEED_ENTRIES];
    max_gap = 3;
    write_lifetime(8'd2);
    for (int i = 0; i < SEED_ENTRIES; i++) begin
      fill_seed[i] = {1'b0, 10'($urandom), 5'(i)};
      send_check(1'b1, LEN_TWO_OCT, fill_seed[i], 16'($urandom), 8'(i), 1'b0);
    end
    send_check(1'b1, LEN_ELIDED, 16'($urandom), 16'hF00D, 8'h10, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hBEEF, 16'h0000, 8'h10, 1'b1);
    send_check(1'b1, LEN_TWO_OCT, fill_seed[SEED_ENTRIES-1], 16'h0000, 8'(SEED_ENTRIES), 1'b0);
    send_check(1'b1, LEN_ELIDED, 16'h0000, fill_seed[5], 8'd5, 1'b1);
    send_ticks(3);
  endtask

  // Lifetime register at one, at zero and at its largest value.
  task automatic test_lifetime_extremes();
    max_gap = 12;
    write_lifetime(8'd1);
    send_check(1'b1, LEN_ELIDED, 16'h0F0F, 16'hC001, 8'h40, 1'b0);
    send_ticks(2);
    send_check(1'b1, LEN_ELIDED, 16'h0F0F, 16'hC001, 8'h40, 1'b0);
    write_lifetime(8'd0);
    send_check(1'b1, LEN_TWO_OCT, 16'hD00D, 16'h0000, 8'h33, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'hD00D, 16'h0000, 8'h33, 1'b0);
    send_ticks(2);
    write_lifetime(8'd255);
    send_check(1'b1, LEN_TWO_OCT, 16'h7E57, 16'h0000, 8'h01, 1'b0);
    send_check(1'b1, LEN_TWO_OCT, 16'h7E57, 16'h0000, 8'h01, 1'b0);
    send_ticks(1);
  endtask

  // One phase of random traffic: mostly pool seeds with near sequences,
  // plus fresh seeds, malformed options and ticks.
  task automatic run_traffic_phase(input logic [LIFE_W-1:0] lifetime, input int count,
                                   input int tick_pct);
    cmd_t              item;
    result_t           predicted;
    int                slot;
    int                pick;
    logic              fresh;
    logic [SEED_W-1:0] seed;
    logic [SEQ_W-1:0]  seq;
    write_lifetime(lifetime);
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_seed[i] = 16'($urandom);
      pool_seq[i]  = 8'($urandom);
    end
    for (int n = 0; n < count; n++) begin
      // Alternate stretches with and without idle gaps.
      max_gap = ((n / 25) % 2 == 0) ? 12 : 0;
      if ($urandom_range(0, 99) < tick_pct) begin
        issue_item(tick_item(), predicted);
        continue;
      end
      slot  = $urandom_range(0, POOL_SIZE - 1);
      fresh = ($urandom_range(0, 9) == 0);
      seed  = fresh ? 16'($urandom) : pool_seed[slot];
      pick  = $urandom_range(0, 99);
      if (pick < 60) begin
        seq = pool_seq[slot] + 8'($urandom_range(1, 4));
      end else if (pick < 72) begin
        seq = pool_seq[slot];
      end else if (pick < 85) begin
        seq = pool_seq[slot] + 8'($urandom_range(128, 255));
      end else begin
        seq = 8'($urandom);
      end
      item = tick_item();
      item.opcode          = OP_CHECK;
      item.option_complete = 1'b1;
      item.sequence_req    = seq;
      item.is_outbound     = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        item.length_code     = LEN_ELIDED;
        item.source_low_bits = seed;
      end else begin
        item.length_code    = LEN_TWO_OCT;
        item.option_seed_id = seed;
      end
      // A few options are broken in one way or the other.
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        item.option_complete = 1'b0;
      end else if (pick < 6) begin
        item.length_code = 2'($urandom_range(2, 3));
      end
      issue_item(item, predicted);
      if (!fresh && predicted.verdict == V_NEW) begin
        pool_seq[slot] = seq;
      end
    end
  endtask

  task automatic test_random_traffic();
    run_traffic_phase(8'd3, 250, 15);
    run_traffic_phase(8'd1, 250, 10);
    run_traffic_phase(8'd0, 100, 10);
    run_traffic_phase(8'd16, 300, 8);
    run_traffic_phase(8'($urandom_range(1, 64)), 300, 8);
    run_traffic_phase(8'd255, 350, 3);
  endtask

  initial begin
    apply_reset();
    test_sequence_rules();
    test_table_full();
    test_lifetime_extremes();
    test_random_traffic();
    settle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
